### rtl/coat_pkg.sv
// ----------------------------------------------------------------------------
// coat_pkg
// Types and codes shared by the control owner timeout arbiter.
// ----------------------------------------------------------------------------
package coat_pkg;

  // Event opcodes
  localparam logic [2:0] OP_APP_REQUEST   = 3'd0;
  localparam logic [2:0] OP_APP_RELEASE   = 3'd1;
  localparam logic [2:0] OP_APP_HEARTBEAT = 3'd2;
  localparam logic [2:0] OP_PAD_ACTIVITY  = 3'd3;
  localparam logic [2:0] OP_PAD_REQUEST   = 3'd4;
  localparam logic [2:0] OP_PAD_CLEAR     = 3'd5;
  localparam logic [2:0] OP_TICK          = 3'd6;
  localparam logic [2:0] OP_NOP           = 3'd7;

  // Register indexes
  localparam logic CFG_APP_TIMEOUT = 1'b0;
  localparam logic CFG_PAD_TIMEOUT = 1'b1;

  localparam logic [31:0] APP_TIMEOUT_RESET = 32'd3000;
  localparam logic [31:0] PAD_TIMEOUT_RESET = 32'd1000;

  // Owner codes as reported
  localparam logic [1:0] OWNER_CODE_NONE = 2'd0;
  localparam logic [1:0] OWNER_CODE_APP  = 2'd1;
  localparam logic [1:0] OWNER_CODE_PAD  = 2'd2;

  typedef enum logic [2:0] {
    ST_NONE = 3'b001,
    ST_APP  = 3'b010,
    ST_PAD  = 3'b100
  } owner_state_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] client_id;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        owner_changed;
    logic [1:0]  current_owner;
    logic [31:0] owning_client;
  } out_item_t;

  typedef struct packed {
    logic [31:0] app_timeout_ms;
    logic [31:0] gamepad_timeout_ms;
  } cfg_t;

endpackage

### rtl/control_owner_timeout_arbiter_unit.sv
// ----------------------------------------------------------------------------
// control_owner_timeout_arbiter_unit
// Arbitrates pan-tilt head ownership between an app client and a gamepad.
// ----------------------------------------------------------------------------
// Takes one event per transfer (opcode, client id, ms timestamp) and returns
// one result per event: accepted, owner_changed, the owner after the event
// and the held app client id. Throughput is one event per clock while the
// result side does not stall. Each event passes through the input register,
// then the update logic in coat_engine into the result register, and a
// result-side stall can hold it in either. Ownership state
// updates as each event moves into the result register, so back-to-back
// events see each other's effects in order. Timeouts are compared on tick
// events as a wrapping 32-bit age, strictly greater than the timeout.
// Timeout registers are written through cfg_we/cfg_index/cfg_data; index 0
// is the app timeout (reset 3000), index 1 the gamepad timeout (reset 1000).
// Write them only while no event is in flight.
module control_owner_timeout_arbiter_unit import coat_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // event input
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t      cfg;
  logic      in_full;
  in_item_t  in_q;
  logic      res_full;
  out_item_t res_q;
  out_item_t result;
  logic      advance;
  logic      in_take;
  logic      out_take;

  // Pipeline moves when the result slot is free or being drained.
  assign advance  = in_full && (!res_full || !out_stall);
  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;
  assign out_take = res_full && !out_stall;

  assign out_valid = res_full;
  assign out_data  = res_q;

  // Timeout registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.app_timeout_ms     <= APP_TIMEOUT_RESET;
      cfg.gamepad_timeout_ms <= PAD_TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_APP_TIMEOUT: cfg.app_timeout_ms     <= cfg_data;
        CFG_PAD_TIMEOUT: cfg.gamepad_timeout_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q <= in_data;
    end
  end

  coat_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (in_q),
    .cfg    (cfg),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_full <= 1'b0;
    end else if (advance) begin
      res_full <= 1'b1;
    end else if (out_take) begin
      res_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= result;
    end
  end

endmodule

### rtl/coat_engine.sv
// ----------------------------------------------------------------------------
// coat_engine
// Ownership state and the per-event update logic.
// ----------------------------------------------------------------------------
module coat_engine import coat_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  owner_state_t owner_state, owner_state_next;
  logic [31:0]  held_client, held_client_next;
  logic [31:0]  last_heartbeat_time, last_heartbeat_time_next;
  logic [31:0]  last_gamepad_time, last_gamepad_time_next;
  logic         accepted, owner_changed;
  logic         app_match;
  logic [31:0]  app_age, pad_age;

  assign app_match = (owner_state == ST_APP) && (held_client == item.client_id);
  assign app_age   = item.now_ms - last_heartbeat_time;
  assign pad_age   = item.now_ms - last_gamepad_time;

  always_comb begin
    owner_state_next         = owner_state;
    held_client_next         = held_client;
    last_heartbeat_time_next = last_heartbeat_time;
    last_gamepad_time_next   = last_gamepad_time;
    accepted                 = 1'b0;
    owner_changed            = 1'b0;
    case (item.opcode)
      OP_APP_REQUEST: begin
        held_client_next         = item.client_id;
        last_heartbeat_time_next = item.now_ms;
        owner_state_next         = ST_APP;
        accepted                 = 1'b1;
      end
      OP_APP_RELEASE: begin
        if (app_match) begin
          held_client_next = '0;
          owner_state_next = ST_NONE;
          accepted         = 1'b1;
        end
      end
      OP_APP_HEARTBEAT: begin
        if (app_match) begin
          last_heartbeat_time_next = item.now_ms;
        end
      end
      OP_PAD_ACTIVITY: begin
        last_gamepad_time_next = item.now_ms;
      end
      OP_PAD_REQUEST: begin
        last_gamepad_time_next = item.now_ms;
        owner_state_next       = ST_PAD;
        accepted               = 1'b1;
      end
      OP_PAD_CLEAR: begin
        if (owner_state == ST_PAD) begin
          owner_state_next = ST_NONE;
        end
        last_gamepad_time_next = '0;
      end
      OP_TICK: begin
        if (owner_state == ST_APP && app_age > cfg.app_timeout_ms) begin
          owner_state_next = ST_NONE;
          held_client_next = '0;
          owner_changed    = 1'b1;
        end else if (owner_state == ST_PAD && pad_age > cfg.gamepad_timeout_ms) begin
          owner_state_next = ST_NONE;
          owner_changed    = 1'b1;
        end
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owner_state         <= ST_NONE;
      held_client         <= '0;
      last_heartbeat_time <= '0;
      last_gamepad_time   <= '0;
    end else if (fire) begin
      owner_state         <= owner_state_next;
      held_client         <= held_client_next;
      last_heartbeat_time <= last_heartbeat_time_next;
      last_gamepad_time   <= last_gamepad_time_next;
    end
  end

  always_comb begin
    result.accepted      = accepted;
    result.owner_changed = owner_changed;
    result.owning_client = held_client_next;
    case (owner_state_next)
      ST_APP:  result.current_owner = OWNER_CODE_APP;
      ST_PAD:  result.current_owner = OWNER_CODE_PAD;
      ST_NONE: result.current_owner = OWNER_CODE_NONE;
      default: result.current_owner = OWNER_CODE_NONE;
    endcase
  end

endmodule

### sim/control_owner_timeout_arbiter_unit_test.sv
// ----------------------------------------------------------------------------
// control_owner_timeout_arbiter_unit_test
// Self-checking bench for the pan-tilt head ownership arbiter.
// ----------------------------------------------------------------------------
// Events go in through the valid/stall input channel and every transfer is
// run through an in-bench ownership model; each result transfer is checked
// field by field against the oldest predicted report. Directed events hit
// requests, releases, heartbeats, gamepad clears and timeout edges (equal age
// holds, one more lapses, wrapping ages). Timeout registers are driven to
// both extremes. Random traffic then runs under three handshake mixes, and a
// back-pressure pass stalls the result side long enough to fill the block.
// ----------------------------------------------------------------------------
module control_owner_timeout_arbiter_unit_test;
  import coat_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000; // cycles with no transfer at all
  localparam int HOLD_CYCLES    = 150;  // long result-side hold-off
  localparam int SETTLE_CYCLES  = 8;    // extra wait after the last report
  localparam int PRINT_LIMIT    = 30;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_APP_TIMEOUT;
  logic [31:0] cfg_data = '0;

  control_owner_timeout_arbiter_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Ownership model: mirrors the arbiter state and its timeout registers.
  logic [1:0]  owner       = OWNER_CODE_NONE;
  logic [31:0] held_id     = '0;
  logic [31:0] app_seen_ms = '0;
  logic [31:0] pad_seen_ms = '0;
  logic [31:0] app_limit   = APP_TIMEOUT_RESET;
  logic [31:0] pad_limit   = PAD_TIMEOUT_RESET;

  out_item_t pending_reports[$];
  out_item_t want_report;

  // Handshake mix, set per test
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Long hold-off: the test bumps hold_asked, the receiver counts it down
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left  = 0;

  int mismatch_count = 0;
  int events_sent    = 0;
  int reports_seen   = 0;
  int lapses_seen    = 0;
  int quiet_cycles   = 0;

  // Random traffic context
  logic [31:0] clock_ms = '0;
  int          step_max = 20;
  logic [31:0] client_pool[4];

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  // Next state and report for one accepted event.
  task automatic apply_event(input in_item_t ev);
    out_item_t   rep;
    logic [31:0] age;
    rep = '0;
    case (ev.opcode)
      OP_APP_REQUEST: begin
        held_id     = ev.client_id;
        app_seen_ms = ev.now_ms;
        owner       = OWNER_CODE_APP;
        rep.accepted = 1'b1;
      end
      OP_APP_RELEASE: begin
        if (owner == OWNER_CODE_APP && held_id == ev.client_id) begin
          held_id = '0;
          owner   = OWNER_CODE_NONE;
          rep.accepted = 1'b1;
        end
      end
      OP_APP_HEARTBEAT: begin
        if (owner == OWNER_CODE_APP && held_id == ev.client_id) app_seen_ms = ev.now_ms;
      end
      OP_PAD_ACTIVITY: begin
        pad_seen_ms = ev.now_ms;
      end
      OP_PAD_REQUEST: begin
        pad_seen_ms = ev.now_ms;
        owner       = OWNER_CODE_PAD;
        rep.accepted = 1'b1;
      end
      OP_PAD_CLEAR: begin
        if (owner == OWNER_CODE_PAD) owner = OWNER_CODE_NONE;
        pad_seen_ms = '0;
      end
      OP_TICK: begin
        // wrapping age, lapse only when strictly past the limit
        if (owner == OWNER_CODE_APP) begin
          age = ev.now_ms - app_seen_ms;
          if (age > app_limit) begin
            owner   = OWNER_CODE_NONE;
            held_id = '0;
            rep.owner_changed = 1'b1;
          end
        end else if (owner == OWNER_CODE_PAD) begin
          age = ev.now_ms - pad_seen_ms;
          if (age > pad_limit) begin
            owner = OWNER_CODE_NONE;  // gamepad lapse keeps held_id
            rep.owner_changed = 1'b1;
          end
        end
      end
      default: ;
    endcase
    rep.current_owner = owner;
    rep.owning_client = held_id;
    pending_reports.push_back(rep);
  endtask

  // Result check first, then prediction, so one process owns the queue.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        reports_seen++;
        if (pending_reports.size() == 0) begin
          report_mismatch($sformatf("report with nothing pending: %h", out_data));
        end else begin
          want_report = pending_reports.pop_front();
          if (want_report.owner_changed) lapses_seen++;
          if (out_data.accepted !== want_report.accepted)
            report_mismatch($sformatf("report %0d accepted: got %b want %b", reports_seen,
                                      out_data.accepted, want_report.accepted));
          if (out_data.owner_changed !== want_report.owner_changed)
            report_mismatch($sformatf("report %0d owner_changed: got %b want %b", reports_seen,
                                      out_data.owner_changed, want_report.owner_changed));
          if (out_data.current_owner !== want_report.current_owner)
            report_mismatch($sformatf("report %0d current_owner: got %0d want %0d",
                                      reports_seen, out_data.current_owner,
                                      want_report.current_owner));
          if (out_data.owning_client !== want_report.owning_client)
            report_mismatch($sformatf("report %0d owning_client: got %h want %h",
                                      reports_seen, out_data.owning_client,
                                      want_report.owning_client));
        end
      end
      if (in_valid && !in_stall) apply_event(in_data);

      // Watchdog: any transfer on either side resets it
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d reports pending",
                 quiet_cycles, pending_reports.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Result side: random stalls, or a long counted hold-off when asked.
  always @(negedge clk) begin
    if (hold_asked != hold_taken) begin
      hold_taken = hold_asked;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // One event transfer. Valid stays high into the next call unless it idles.
  task automatic send_event(input logic [2:0] op, input logic [31:0] id,
                            input logic [31:0] now);
    in_item_t ev;
    ev.opcode    = op;
    ev.client_id = id;
    ev.now_ms    = now;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (!(in_valid && !in_stall));
    events_sent++;
  endtask

  // Mostly well-formed traffic around a moving clock, some wild values.
  task automatic send_random_event();
    int          pick;
    logic [2:0]  op;
    logic [31:0] id;
    logic [31:0] now;
    pick = $urandom_range(0, 99);
    if      (pick < 12) op = OP_APP_REQUEST;
    else if (pick < 22) op = OP_APP_RELEASE;
    else if (pick < 40) op = OP_APP_HEARTBEAT;
    else if (pick < 50) op = OP_PAD_ACTIVITY;
    else if (pick < 58) op = OP_PAD_REQUEST;
    else if (pick < 64) op = OP_PAD_CLEAR;
    else if (pick < 95) op = OP_TICK;
    else                op = OP_NOP;
    id = ($urandom_range(0, 9) == 0) ? $urandom : client_pool[$urandom_range(0, 3)];
    clock_ms += $urandom_range(0, step_max);
    now = ($urandom_range(0, 19) == 0) ? $urandom : clock_ms;
    send_event(op, id, now);
  endtask

  // Drop valid and wait for every predicted report, then a little more.
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_timeout(input logic idx, input logic [31:0] value);
    settle_block();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_APP_TIMEOUT) app_limit = value;
    else pad_limit = value;
  endtask

  // Reset timeouts (3000 / 1000) and every opcode's special handling.
  task automatic test_directed_events();
    send_event(OP_TICK,          32'h0,        32'h0);        // tick, no owner
    send_event(OP_NOP,           32'hFFFFFFFF, 32'hFFFFFFFF);
    send_event(OP_APP_REQUEST,   32'hFFFFFFFF, 32'hFFFFFFFF);
    send_event(OP_APP_HEARTBEAT, 32'd5,        32'd50);       // not the owner
    send_event(OP_APP_HEARTBEAT, 32'hFFFFFFFF, 32'd100);      // wraps forward
    send_event(OP_APP_RELEASE,   32'd5,        32'd200);      // wrong client
    send_event(OP_TICK,          32'd0,        32'd3100);     // age == limit
    send_event(OP_TICK,          32'd0,        32'd3101);     // app lapses
    send_event(OP_APP_RELEASE,   32'd0,        32'd0);        // id matches, no app
    send_event(OP_APP_REQUEST,   32'd7,        32'd10);
    send_event(OP_PAD_REQUEST,   32'd0,        32'd20);       // pad takes over
    send_event(OP_APP_RELEASE,   32'd7,        32'd30);       // owner is pad
    send_event(OP_PAD_ACTIVITY,  32'd0,        32'd500);
    send_event(OP_TICK,          32'd0,        32'd1500);     // age == limit
    send_event(OP_TICK,          32'd0,        32'd1501);     // pad lapses
    send_event(OP_PAD_CLEAR,     32'd0,        32'd0);        // no owner
    send_event(OP_PAD_REQUEST,   32'd0,        32'hFFFFFF00);
    send_event(OP_TICK,          32'd0,        32'h000002E7); // wrapped age 999
    send_event(OP_APP_REQUEST,   32'd9,        32'd30);       // app over pad
    send_event(OP_PAD_CLEAR,     32'd0,        32'd31);       // app keeps head
    send_event(OP_APP_RELEASE,   32'd9,        32'd32);
    send_event(OP_PAD_REQUEST,   32'd0,        32'd40);
    send_event(OP_PAD_CLEAR,     32'd0,        32'd41);
    send_event(OP_TICK,          32'd0,        32'hFFFFFFFF);
    send_event(OP_NOP,           32'd0,        32'd0);
  endtask

  // Zero timeout lapses after one ms; all-ones never lapses.
  task automatic test_timeout_extremes();
    set_timeout(CFG_APP_TIMEOUT, 32'd0);
    set_timeout(CFG_PAD_TIMEOUT, 32'd0);
    send_event(OP_APP_REQUEST, 32'd1, 32'd5);
    send_event(OP_TICK,        32'd0, 32'd5);
    send_event(OP_TICK,        32'd0, 32'd6);
    send_event(OP_PAD_REQUEST, 32'd0, 32'd0);
    send_event(OP_TICK,        32'd0, 32'd0);
    send_event(OP_TICK,        32'd0, 32'd1);
    set_timeout(CFG_APP_TIMEOUT, 32'hFFFFFFFF);
    set_timeout(CFG_PAD_TIMEOUT, 32'hFFFFFFFF);
    send_event(OP_APP_REQUEST, 32'd2, 32'd0);
    send_event(OP_TICK,        32'd0, 32'hFFFFFFFF);
    send_event(OP_PAD_REQUEST, 32'd0, 32'd10);
    send_event(OP_TICK,        32'd0, 32'd9);
    send_event(OP_PAD_CLEAR,   32'd0, 32'd11);
  endtask

  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct,
                                     input int app_max, input int pad_max);
    set_timeout(CFG_APP_TIMEOUT, $urandom_range(0, app_max));
    set_timeout(CFG_PAD_TIMEOUT, $urandom_range(0, pad_max));
    foreach (client_pool[i]) client_pool[i] = $urandom;
    clock_ms      = $urandom;  // start anywhere so the clock wraps now and then
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_random_event();
  endtask

  // Hold the result side while events keep coming, then let the sender pause
  // until the block has drained before going on.
  task automatic test_backpressure();
    settle_block();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asked++;
    repeat (60) send_random_event();
    settle_block();
    recv_idle_pct = 30;
    repeat (30) send_random_event();
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    test_directed_events();
    test_timeout_extremes();
    test_random_traffic(500, 36, 59, 80, 50);
    test_random_traffic(500, 59, 36, 60, 40);
    test_random_traffic(500, 0, 0, 200, 120);
    test_backpressure();

    settle_block();
    if (pending_reports.size() != 0)
      report_mismatch($sformatf("%0d reports never arrived", pending_reports.size()));

    $display("Ran %0d events and checked %0d reports, %0d of them timeout lapses,",
             events_sent, reports_seen, lapses_seen);
    $display("over both timeout extremes, three handshake mixes and a long result stall.");
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
rtl/coat_pkg.sv
rtl/coat_engine.sv
rtl/control_owner_timeout_arbiter_unit.sv
sim/control_owner_timeout_arbiter_unit_test.sv
